/* src/pdps_pkg.sv */
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared types and constants of the dashed polyline splitter.
// ----------------------------------------------------------------------------
package pdps_pkg;

	localparam int COORD_BITS   = 32;
	localparam int LEN_BITS     = 32;
	localparam int CNT_BITS     = 3;
	localparam int POS_BITS     = 3;
	localparam int MAX_PATTERN  = 6;
	localparam int RESULT_LIMIT = 64;
	localparam int QUEUE_DEPTH  = 2;

	localparam int MAG_BITS  = COORD_BITS + 1;
	localparam int SEG_BITS  = COORD_BITS + 2;
	localparam int PROD_BITS = MAG_BITS + SEG_BITS;
	localparam int SQ_BITS   = 2 * SEG_BITS;

	localparam int REG_PATTERN_COUNT = 0;
	localparam int REG_LENGTH_0      = 1;

	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(65536);
	localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(2);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         first_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         run_end;
		logic                         overflow;
	} point_t;

	typedef struct packed {
		vertex_t                      v;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
	} seg_job_t;

	typedef struct packed {
		logic                busy;
		logic [POS_BITS-1:0] pos;
	} back_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_STEP,
		ST_DIV,
		ST_PUT,
		ST_TAIL
	} back_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_phase_t;

	function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [COORD_BITS-1:0] e,
		input logic signed [COORD_BITS-1:0] s);
		logic [MAG_BITS-1:0] d;
		d = {e[COORD_BITS-1], e} - {s[COORD_BITS-1], s};
		return d[MAG_BITS-1] ? (~d + MAG_BITS'(1)) : d;
	endfunction

endpackage

/* src/pdps_fifo.sv */
// ----------------------------------------------------------------------------
// pdps_fifo
// Short job queue between the vertex front end and the stroke back end.
// ----------------------------------------------------------------------------
module pdps_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pdps_pkg::seg_job_t  push_data,
	output logic                full,
	input  logic                pop,
	output logic                rd_valid,
	output pdps_pkg::seg_job_t  rd_data
);

	localparam int D  = pdps_pkg::QUEUE_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	pdps_pkg::seg_job_t mem_q [D];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(D));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

/* src/pdps_front.sv */
// ----------------------------------------------------------------------------
// pdps_front
// Accepts vertices, tracks the previous vertex and drops repeated ones.
// ----------------------------------------------------------------------------
module pdps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pdps_pkg::vertex_t   in_word,
	output logic                push,
	output pdps_pkg::seg_job_t  push_data,
	input  logic                full
);

	logic signed [pdps_pkg::COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic started_q;
	logic acc, first, rep;

	assign in_stall = full;
	assign acc      = in_valid && !full;
	assign first    = in_word.first_vertex || !started_q;
	assign rep      = !first && (in_word.vertex_x == prev_x_q) && (in_word.vertex_y == prev_y_q);
	assign push     = acc && !rep;

	always_comb begin
		push_data                = '0;
		push_data.v              = in_word;
		push_data.v.first_vertex = first;
		push_data.start_x        = prev_x_q;
		push_data.start_y        = prev_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			started_q <= 1'b0;
		end else if (push) begin
			prev_x_q  <= in_word.vertex_x;
			prev_y_q  <= in_word.vertex_y;
			started_q <= 1'b1;
		end
	end

endmodule

/* src/pdps_muldiv.sv */
// ----------------------------------------------------------------------------
// pdps_muldiv
// Shift-add multiplier with an optional restoring divide of the product.
// ----------------------------------------------------------------------------
module pdps_muldiv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             do_div,
	input  logic [pdps_pkg::MAG_BITS-1:0]    a,
	input  logic [pdps_pkg::SEG_BITS-1:0]    b,
	input  logic [pdps_pkg::SEG_BITS-1:0]    d,
	output logic                             done,
	output logic [pdps_pkg::PROD_BITS-1:0]   prod,
	output logic [pdps_pkg::MAG_BITS-1:0]    quot
);

	localparam int MW = pdps_pkg::MAG_BITS;
	localparam int SW = pdps_pkg::SEG_BITS;
	localparam int PW = pdps_pkg::PROD_BITS;
	localparam int CW = $clog2(SW + 1);

	pdps_pkg::md_phase_t phase_q;
	logic [PW-1:0] acc_q, mcand_q, acc_n;
	logic [SW-1:0] mplier_q, rem_q, d_q;
	logic [MW-1:0] src_q;
	logic [CW-1:0] cnt_q;
	logic          div_q, done_q;
	logic [SW:0]   rem2;
	logic          ge;

	assign acc_n = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign rem2  = {rem_q, src_q[MW-1]};
	assign ge    = (rem2 >= {1'b0, d_q});
	assign done  = done_q;
	assign prod  = acc_q;
	assign quot  = src_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PW'(a);
			mplier_q <= b;
			d_q      <= d;
			div_q    <= do_div;
		end else if (phase_q == pdps_pkg::MD_MUL) begin
			acc_q    <= acc_n;
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[SW-1:1]};
			if (cnt_q == CW'(1)) begin
				rem_q <= acc_n[PW-1:MW];
				src_q <= acc_n[MW-1:0];
			end
		end else if (phase_q == pdps_pkg::MD_DIV) begin
			rem_q <= ge ? SW'(rem2 - {1'b0, d_q}) : rem2[SW-1:0];
			src_q <= {src_q[MW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pdps_pkg::MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				pdps_pkg::MD_IDLE: begin
					if (start) begin
						phase_q <= pdps_pkg::MD_MUL;
						cnt_q   <= CW'(SW);
					end
				end
				pdps_pkg::MD_MUL: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						if (div_q) begin
							phase_q <= pdps_pkg::MD_DIV;
							cnt_q   <= CW'(MW);
						end else begin
							phase_q <= pdps_pkg::MD_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				pdps_pkg::MD_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						phase_q <= pdps_pkg::MD_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= pdps_pkg::MD_IDLE;
			endcase
		end
	end

endmodule

/* src/pdps_isqrt.sv */
// ----------------------------------------------------------------------------
// pdps_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pdps_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pdps_pkg::SQ_BITS-1:0]     v,
	output logic                             done,
	output logic [pdps_pkg::SEG_BITS-1:0]    root
);

	localparam int RW = pdps_pkg::SEG_BITS;
	localparam int VW = pdps_pkg::SQ_BITS;
	localparam int CW = $clog2(RW + 1);

	logic [VW-1:0]  src_q;
	logic [RW+2:0]  rem_q, sh, trial;
	logic [RW-1:0]  root_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q, ge;

	assign sh    = {rem_q[RW:0], src_q[VW-1:VW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (sh >= trial);
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			src_q  <= {src_q[VW-3:0], 2'b00};
			rem_q  <= ge ? sh - trial : sh;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* src/pdps_back.sv */
// ----------------------------------------------------------------------------
// pdps_back
// Walks the dash pattern along each segment and emits the cut points.
// ----------------------------------------------------------------------------
module pdps_back #(
	parameter int MAX_PATTERN  = pdps_pkg::MAX_PATTERN,
	parameter int RESULT_LIMIT = pdps_pkg::RESULT_LIMIT,
	parameter int IDX_BITS     = $clog2(MAX_PATTERN + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [IDX_BITS-1:0]              cfg_index,
	input  logic [pdps_pkg::LEN_BITS-1:0]    cfg_data,
	input  logic                             job_valid,
	input  pdps_pkg::seg_job_t               job,
	output logic                             job_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pdps_pkg::point_t                 out_word,
	output pdps_pkg::back_status_t           status
);

	localparam int CB = pdps_pkg::COORD_BITS;
	localparam int SW = pdps_pkg::SEG_BITS;
	localparam int LW = pdps_pkg::LEN_BITS;
	localparam int PB = pdps_pkg::POS_BITS;
	localparam int NW = $clog2(RESULT_LIMIT);
	localparam logic [PB:0] MAX_EVEN = (PB + 1)'(MAX_PATTERN - MAX_PATTERN % 2);

	pdps_pkg::back_state_t state_q, state_d, ret_q;
	pdps_pkg::point_t      pend_q, out_q;
	logic                  out_valid_q, out_free;
	logic [pdps_pkg::CNT_BITS-1:0] pc_q;
	logic [LW-1:0]         len_q [MAX_PATTERN];
	logic [NW-1:0]         n_q;
	logic [SW-1:0]         seg_q, rem_q, cons_q, left_ext, cons_n;
	logic [LW-1:0]         left_q, len_adv, len0;
	logic [PB-1:0]         pos_q, p_adv;
	logic [PB:0]           cnt_use, p1;
	logic signed [CB-1:0]  x_q, y_q, sx_q, sy_q, qx, qy;
	logic                  lim;

	logic                  ln_start, ln_div, ln_done_x, ln_done_y;
	logic [pdps_pkg::MAG_BITS-1:0]  ax, ay, quot_x, quot_y;
	logic [SW-1:0]                  bx, by;
	logic [pdps_pkg::PROD_BITS-1:0] prod_x, prod_y;
	logic                           rt_start, rt_done;
	logic [pdps_pkg::SQ_BITS-1:0]   rt_v;
	logic [SW-1:0]                  rt_root;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign status    = '{busy: (state_q != pdps_pkg::ST_IDLE), pos: pos_q};
	assign left_ext  = SW'(left_q);
	assign cons_n    = cons_q + left_ext;
	assign lim       = (n_q == NW'(RESULT_LIMIT - 1));
	assign qx        = quot_x[CB-1:0];
	assign qy        = quot_y[CB-1:0];

	always_comb begin
		cnt_use = {1'b0, pc_q[2:1], 1'b0};
		if (cnt_use < (PB + 1)'(2))
			cnt_use = (PB + 1)'(2);
		if (cnt_use > MAX_EVEN)
			cnt_use = MAX_EVEN;
		p1    = {1'b0, pos_q} + (PB + 1)'(1);
		p_adv = (p1 >= cnt_use) ? '0 : p1[PB-1:0];
		len_adv = len_q[0];
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (p_adv == PB'(i))
				len_adv = len_q[i];
		end
		if (len_adv == '0)
			len_adv = LW'(1);
		len0 = (len_q[0] == '0) ? LW'(1) : len_q[0];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= pdps_pkg::CNT_RESET;
			for (int i = 0; i < MAX_PATTERN; i++)
				len_q[i] <= pdps_pkg::LEN_RESET;
		end else if (cfg_write) begin
			if (cfg_index == IDX_BITS'(pdps_pkg::REG_PATTERN_COUNT))
				pc_q <= cfg_data[pdps_pkg::CNT_BITS-1:0];
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (cfg_index == IDX_BITS'(pdps_pkg::REG_LENGTH_0 + i))
					len_q[i] <= cfg_data;
			end
		end
	end

	// lane operands, job pop and next state
	always_comb begin
		ln_start = 1'b0;
		ln_div   = 1'b0;
		ax       = pdps_pkg::mag_of(x_q, sx_q);
		ay       = pdps_pkg::mag_of(y_q, sy_q);
		bx       = cons_n;
		by       = cons_n;
		rt_start = 1'b0;
		rt_v     = SW'(0) + pdps_pkg::SQ_BITS'(prod_x) + pdps_pkg::SQ_BITS'(prod_y);
		job_pop  = 1'b0;
		state_d  = state_q;
		case (state_q)
			pdps_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					if (!job.v.first_vertex) begin
						ln_start = 1'b1;
						ax       = pdps_pkg::mag_of(job.v.vertex_x, job.start_x);
						ay       = pdps_pkg::mag_of(job.v.vertex_y, job.start_y);
						bx       = SW'(ax);
						by       = SW'(ay);
						state_d  = pdps_pkg::ST_SQ;
					end else begin
						state_d = pdps_pkg::ST_PUT;
					end
				end
			end
			pdps_pkg::ST_SQ: begin
				if (ln_done_x) begin
					rt_start = 1'b1;
					state_d  = pdps_pkg::ST_ROOT;
				end
			end
			pdps_pkg::ST_ROOT: begin
				if (rt_done)
					state_d = pdps_pkg::ST_STEP;
			end
			pdps_pkg::ST_STEP: begin
				if (left_q == '0) begin
					state_d = pdps_pkg::ST_STEP;
				end else if (rem_q <= left_ext) begin
					state_d = pdps_pkg::ST_PUT;
				end else begin
					ln_start = 1'b1;
					ln_div   = 1'b1;
					state_d  = pdps_pkg::ST_DIV;
				end
			end
			pdps_pkg::ST_DIV: begin
				if (ln_done_x)
					state_d = pdps_pkg::ST_PUT;
			end
			pdps_pkg::ST_TAIL: state_d = pdps_pkg::ST_PUT;
			pdps_pkg::ST_PUT: begin
				if (out_free)
					state_d = pend_q.run_end ? pdps_pkg::ST_IDLE : ret_q;
			end
			default: state_d = pdps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pdps_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			left_q      <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			ret_q       <= pdps_pkg::ST_IDLE;
		end else begin
			if (out_valid_q && !out_stall && state_q != pdps_pkg::ST_PUT)
				out_valid_q <= 1'b0;
			case (state_q)
				pdps_pkg::ST_IDLE: begin
					if (job_valid) begin
						n_q <= '0;
						if (job.v.first_vertex) begin
							pos_q  <= '0;
							left_q <= len0;
						end
					end
				end
				pdps_pkg::ST_STEP: begin
					if (left_q == '0) begin
						pos_q  <= p_adv;
						left_q <= len_adv;
					end else if (rem_q == left_ext) begin
						pos_q  <= p_adv;
						left_q <= len_adv;
					end else if (rem_q < left_ext) begin
						ret_q <= pdps_pkg::ST_TAIL;
						if (lim) begin
							pos_q  <= '0;
							left_q <= len0;
						end else begin
							left_q <= left_q - rem_q[LW-1:0];
						end
					end
				end
				pdps_pkg::ST_DIV: begin
					if (ln_done_x) begin
						ret_q <= pdps_pkg::ST_STEP;
						if (lim) begin
							pos_q  <= '0;
							left_q <= len0;
						end else begin
							pos_q  <= p_adv;
							left_q <= len_adv;
						end
					end
				end
				pdps_pkg::ST_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						n_q         <= n_q + NW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pdps_pkg::ST_IDLE: begin
				if (job_valid) begin
					x_q    <= job.v.vertex_x;
					y_q    <= job.v.vertex_y;
					sx_q   <= job.start_x;
					sy_q   <= job.start_y;
					pend_q <= '{point_x: job.v.vertex_x, point_y: job.v.vertex_y,
						run_end: 1'b1, overflow: 1'b0};
				end
			end
			pdps_pkg::ST_ROOT: begin
				if (rt_done) begin
					seg_q  <= rt_root;
					rem_q  <= rt_root;
					cons_q <= '0;
				end
			end
			pdps_pkg::ST_STEP: begin
				if (left_q != '0) begin
					if (rem_q == left_ext)
						pend_q <= '{point_x: x_q, point_y: y_q, run_end: 1'b1, overflow: 1'b0};
					else if (rem_q < left_ext)
						pend_q <= '{point_x: x_q, point_y: y_q, run_end: lim, overflow: lim};
					else begin
						cons_q <= cons_n;
						rem_q  <= rem_q - left_ext;
					end
				end
			end
			pdps_pkg::ST_DIV: begin
				if (ln_done_x) begin
					pend_q.point_x  <= (x_q < sx_q) ? sx_q - qx : sx_q + qx;
					pend_q.point_y  <= (y_q < sy_q) ? sy_q - qy : sy_q + qy;
					pend_q.run_end  <= lim;
					pend_q.overflow <= lim;
				end
			end
			pdps_pkg::ST_TAIL:
				pend_q <= '{point_x: x_q, point_y: y_q, run_end: 1'b1, overflow: 1'b0};
			pdps_pkg::ST_PUT: begin
				if (out_free)
					out_q <= pend_q;
			end
			default: ;
		endcase
	end

	pdps_muldiv u_lane_x (
		.clk(clk), .arst_n(arst_n), .start(ln_start), .do_div(ln_div),
		.a(ax), .b(bx), .d(seg_q), .done(ln_done_x), .prod(prod_x), .quot(quot_x)
	);

	pdps_muldiv u_lane_y (
		.clk(clk), .arst_n(arst_n), .start(ln_start), .do_div(ln_div),
		.a(ay), .b(by), .d(seg_q), .done(ln_done_y), .prod(prod_y), .quot(quot_y)
	);

	pdps_isqrt u_root (
		.clk(clk), .arst_n(arst_n), .start(rt_start && ln_done_y), .v(rt_v),
		.done(rt_done), .root(rt_root)
	);

endmodule

/* src/polyline_dash_pattern_splitter.sv */
// ----------------------------------------------------------------------------
// polyline_dash_pattern_splitter
// Splits a polyline into dash and gap pieces, one vertex word in, points out.
// ----------------------------------------------------------------------------
// channel   dir  handshake            word
// in        in   in_valid/in_stall    vertex_x, vertex_y, first_vertex
// out       out  out_valid/out_stall  point_x, point_y, run_end, overflow
// cfg       in   cfg_write            cfg_index, cfg_data
//
// a first vertex goes straight to the output; a segment is squared in the
// lanes, its length is taken by the root and each cut point is found by
// the shared multiply/divide lanes; each point then takes an output step,
// and the closing vertex may go out twice
// repeated vertices are dropped at the front
// a two-word queue lets the front keep taking words while the back works
// a stalled output holds the back end; reset clears all control state at once
// ----------------------------------------------------------------------------
module polyline_dash_pattern_splitter #(
	parameter int MAX_PATTERN  = pdps_pkg::MAX_PATTERN,
	parameter int RESULT_LIMIT = pdps_pkg::RESULT_LIMIT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  pdps_pkg::vertex_t                          in_word,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output pdps_pkg::point_t                           out_word,
	input  logic                                       cfg_write,
	input  logic [$clog2(MAX_PATTERN + 1)-1:0]         cfg_index,
	input  logic [pdps_pkg::LEN_BITS-1:0]              cfg_data
);

	localparam int IW = $clog2(MAX_PATTERN + 1);

	logic                   push, full, pop, rd_valid;
	pdps_pkg::seg_job_t     push_data, rd_data;
	pdps_pkg::back_status_t status;

	pdps_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .push(push), .push_data(push_data), .full(full)
	);

	pdps_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .rd_valid(rd_valid), .rd_data(rd_data)
	);

	pdps_back #(
		.MAX_PATTERN(MAX_PATTERN), .RESULT_LIMIT(RESULT_LIMIT), .IDX_BITS(IW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .job_valid(rd_valid), .job(rd_data), .job_pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.status(status)
	);

	a_ovf_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.overflow |-> out_word.run_end)
		else $error("overflow word not marked last");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> (32'(status.pos) < MAX_PATTERN))
		else $error("pattern position out of range");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid && !status.busy)
		else $error("queue popped while back end busy");

endmodule
